@@ rtl/core/srpl_pkg.sv @@
package srpl_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 16;
    localparam int NUM_W      = 2 * DIV_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int RAD_W      = 2 * SQRT_STEPS;

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] clamped_x;
        logic signed [15:0] clamped_y;
        logic               was_outside;
        logic signed [23:0] scale_value;
    } t_out_word;

    typedef enum logic [2:0] {
        K_ROUND,
        K_OUT,
        K_ORIGIN,
        K_AXIS,
        K_GEN
    } t_kind;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        t_kind              kind;
        logic               axge;
        logic               neg;
        logic [31:0]        sum;
    } t_side;

endpackage

@@ rtl/core/srpl_div.sv @@
module srpl_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [srpl_pkg::NUM_W-1:0]  i_num,
    input  logic [srpl_pkg::DIV_STEPS-1:0] i_den,
    output logic [srpl_pkg::DIV_STEPS-1:0] o_quo
);
    import srpl_pkg::*;

    logic [DIV_STEPS-1:0] r_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_lo  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_lo  [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_den [DIV_STEPS];

    // quotient bits shift into the low word as the numerator bits leave it
    always_comb begin
        logic [DIV_STEPS-1:0] rem_in;
        logic [DIV_STEPS-1:0] lo_in;
        logic [DIV_STEPS-1:0] den_in;
        logic [DIV_STEPS:0]   t;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in = i_num[NUM_W-1:DIV_STEPS];
                lo_in  = i_num[DIV_STEPS-1:0];
                den_in = i_den;
            end else begin
                rem_in = r_rem[k-1];
                lo_in  = r_lo[k-1];
                den_in = r_den[k-1];
            end
            t = {rem_in, lo_in[DIV_STEPS-1]};
            n_den[k] = den_in;
            if (t >= {1'b0, den_in}) begin
                n_rem[k] = DIV_STEPS'(t - {1'b0, den_in});
                n_lo[k]  = {lo_in[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DIV_STEPS-1:0];
                n_lo[k]  = {lo_in[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_lo[DIV_STEPS-1];

endmodule

@@ rtl/core/srpl_sqrt.sv @@
module srpl_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [srpl_pkg::RAD_W-1:0]  i_rad,
    output logic [srpl_pkg::ROOT_W-1:0] o_root
);
    import srpl_pkg::*;

    logic [RAD_W-1:0] r_v   [SQRT_STEPS];
    logic [RAD_W-1:0] r_res [SQRT_STEPS];
    logic [RAD_W-1:0] n_v   [SQRT_STEPS];
    logic [RAD_W-1:0] n_res [SQRT_STEPS];

    always_comb begin
        logic [RAD_W-1:0] v_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] bitv;
        logic [RAD_W:0]   trial;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            if (k == 0) begin
                v_in   = i_rad;
                res_in = '0;
            end else begin
                v_in   = r_v[k-1];
                res_in = r_res[k-1];
            end
            bitv  = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            trial = {1'b0, res_in} + {1'b0, bitv};
            if ({1'b0, v_in} >= trial) begin
                n_v[k]   = RAD_W'({1'b0, v_in} - trial);
                n_res[k] = (res_in >> 1) + bitv;
            end else begin
                n_v[k]   = v_in;
                n_res[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_v[k]   <= n_v[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

@@ rtl/core/square_radar_point_limit.sv @@
// Pipeline: 4 front stages, 32 divider stages, 16 square-root stages and 1
// output register lie between input accept and o_valid.
// Throughput: one word per cycle unless o_valid waits on low i_ready; the
// restoring divider and the square-root pipeline each retire one per cycle.
// Reset: synchronous active-low i_rst_n clears all valid bits and round_mode.
module square_radar_point_limit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  srpl_pkg::t_in_word   i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output srpl_pkg::t_out_word  o_word,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data
);
    import srpl_pkg::*;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'sd32767;
        end else if (v < -34'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        if (v > 34'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -34'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    logic        r_round;
    logic        en;

    // stage 1
    logic        r_v1;
    t_side       r_s1;
    logic [15:0] r_m1, r_n1;
    // stage 2
    logic        r_v2;
    t_side       r_s2;
    logic [31:0] r_mm2, r_nn2, r_dd2;
    logic [NUM_W-1:0]     r_nax2, r_ng2, r_nb2;
    logic [DIV_STEPS-1:0] r_dax2, r_dg2, r_db2;
    // stage 3
    logic        r_v3;
    t_side       r_s3;
    logic [31:0] r_mm3, r_dd3;
    logic [NUM_W-1:0]     r_nax3, r_ng3, r_nb3;
    logic [DIV_STEPS-1:0] r_dax3, r_dg3, r_db3;
    // stage 4: divider operands
    logic        r_v4;
    t_side       r_s4;
    logic [NUM_W-1:0]     r_na4, r_nb4;
    logic [DIV_STEPS-1:0] r_da4, r_db4;

    logic        r_dv [DIV_STEPS];
    t_side       r_ds [DIV_STEPS];
    logic        r_qv [SQRT_STEPS];
    t_side       r_qs [SQRT_STEPS];
    logic [DIV_STEPS-1:0] r_qa [SQRT_STEPS];
    logic [DIV_STEPS-1:0] r_qb [SQRT_STEPS];

    logic        r_ov;
    t_out_word   r_out;

    logic [DIV_STEPS-1:0] quo_a, quo_b;
    logic [RAD_W-1:0]     rad;
    logic [ROOT_W-1:0]    root;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= 1'b0;
        end else if (i_cfg_we) begin
            r_round <= i_cfg_data;
        end
    end

    // front end: magnitudes and case
    logic [15:0] ax, ay, mx, mn;
    t_kind       kind0;
    always_comb begin
        ax = i_word.point_x[15] ? 16'(-i_word.point_x) : 16'(i_word.point_x);
        ay = i_word.point_y[15] ? 16'(-i_word.point_y) : 16'(i_word.point_y);
        mx = (ax > ay) ? ax : ay;
        mn = (ax > ay) ? ay : ax;
        if (r_round) begin
            kind0 = K_ROUND;
        end else if (32'(mx) >= ONE) begin
            kind0 = K_OUT;
        end else if (mx == 16'd0) begin
            kind0 = K_ORIGIN;
        end else if (mn == 16'd0) begin
            kind0 = K_AXIS;
        end else begin
            kind0 = K_GEN;
        end
    end

    logic [16:0] m2;
    logic [16:0] mag2;
    logic [31:0] one_m;
    assign m2    = {r_m1, 1'b0};
    assign mag2  = r_s1.neg ? 17'(ONE - 32'(m2)) : 17'(32'(m2) - ONE);
    assign one_m = ONE - 32'(r_m1);

    t_side s3_in;
    always_comb begin
        s3_in     = r_s2;
        s3_in.sum = r_mm2 + r_nn2;
    end

    logic [NUM_W-1:0] prod3;
    assign prod3 = NUM_W'(r_dd3) * NUM_W'(r_s3.sum);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.x    <= i_word.point_x;
            r_s1.y    <= i_word.point_y;
            r_s1.kind <= kind0;
            r_s1.axge <= (ax >= ay);
            r_s1.neg  <= (32'(mx) << 1) < ONE;
            r_s1.sum  <= '0;
            r_m1      <= mx;
            r_n1      <= mn;

            r_s2      <= r_s1;
            r_mm2     <= r_m1 * r_m1;
            r_nn2     <= r_n1 * r_n1;
            r_dd2     <= 32'(16'(32'(r_m1) - ONE)) * 32'(16'(32'(r_m1) - ONE));
            r_nax2    <= (NUM_W'(mag2) << (FRAC_BITS + 1)) + NUM_W'(r_m1);
            r_dax2    <= DIV_STEPS'(m2);
            r_ng2     <= (NUM_W'(r_m1) << (FRAC_BITS + 1)) + NUM_W'(one_m);
            r_dg2     <= one_m << 1;
            r_nb2     <= (NUM_W'(r_n1) << (FRAC_BITS + 1)) + NUM_W'(r_m1);
            r_db2     <= DIV_STEPS'(m2);

            r_s3      <= s3_in;
            r_mm3     <= r_mm2;
            r_dd3     <= r_dd2;
            r_nax3    <= r_nax2;
            r_dax3    <= r_dax2;
            r_ng3     <= r_ng2;
            r_dg3     <= r_dg2;
            r_nb3     <= r_nb2;
            r_db3     <= r_db2;

            r_s4      <= r_s3;
            r_nb4     <= r_nb3;
            r_db4     <= r_db3;
            case (r_s3.kind)
                K_OUT: begin
                    r_na4 <= prod3;
                    r_da4 <= r_mm3;
                end
                K_AXIS: begin
                    r_na4 <= r_nax3;
                    r_da4 <= r_dax3;
                end
                K_GEN: begin
                    r_na4 <= r_ng3;
                    r_da4 <= r_dg3;
                end
                default: begin
                    r_na4 <= '0;
                    r_da4 <= DIV_STEPS'(1);
                end
            endcase

            r_ds[0] <= r_s4;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_ds[k] <= r_ds[k-1];
            end

            r_qs[0] <= r_ds[DIV_STEPS-1];
            r_qa[0] <= quo_a;
            r_qb[0] <= quo_b;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_qs[k] <= r_qs[k-1];
                r_qa[k] <= r_qa[k-1];
                r_qb[k] <= r_qb[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv[k] <= 1'b0;
            end
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_qv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_dv[0] <= r_v4;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_qv[0] <= r_dv[DIV_STEPS-1];
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_qv[k] <= r_qv[k-1];
            end
            r_ov <= r_qv[SQRT_STEPS-1];
        end
    end

    srpl_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_na4),
        .i_den (r_da4),
        .o_quo (quo_a)
    );

    srpl_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nb4),
        .i_den (r_db4),
        .o_quo (quo_b)
    );

    assign rad = (r_ds[DIV_STEPS-1].kind == K_ROUND) ? r_ds[DIV_STEPS-1].sum : quo_a;

    srpl_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad),
        .o_root (root)
    );

    // final assembly
    t_side              fs;
    logic signed [33:0] sc, qa_s, minor_s, pin_s, cx_s, cy_s;
    t_out_word          n_out;
    always_comb begin
        fs      = r_qs[SQRT_STEPS-1];
        qa_s    = $signed({2'b00, r_qa[SQRT_STEPS-1]});
        minor_s = $signed({2'b00, r_qb[SQRT_STEPS-1]});
        pin_s   = $signed({2'b00, ONE});
        cx_s    = 34'(fs.x);
        cy_s    = 34'(fs.y);
        case (fs.kind)
            K_ROUND: sc = $signed({18'd0, root});
            K_OUT: begin
                sc = $signed({18'd0, root}) + pin_s;
                if (fs.axge) begin
                    cx_s = fs.x[15] ? -pin_s : pin_s;
                    cy_s = fs.y[15] ? -minor_s : minor_s;
                end else begin
                    cy_s = fs.y[15] ? -pin_s : pin_s;
                    cx_s = fs.x[15] ? -minor_s : minor_s;
                end
            end
            K_AXIS:  sc = fs.neg ? -qa_s : qa_s;
            K_GEN:   sc = -qa_s;
            default: sc = '0;
        endcase
        n_out.clamped_x   = sat16(cx_s);
        n_out.clamped_y   = sat16(cy_s);
        n_out.was_outside = (fs.kind == K_OUT);
        n_out.scale_value = sat24(sc);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/core/srpl_checker.sv @@
module srpl_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input srpl_pkg::t_out_word  o_word
);
    import srpl_pkg::*;

    localparam logic signed [15:0] PIN = 16'(ONE);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word))
        else $error("output word changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_out_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.was_outside |-> o_word.scale_value >= 24'(ONE))
        else $error("outside word with scale below one");

    a_out_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.was_outside |->
            (o_word.clamped_x == PIN || o_word.clamped_x == -PIN ||
             o_word.clamped_y == PIN || o_word.clamped_y == -PIN))
        else $error("outside word with no axis pinned to the edge");

endmodule

bind square_radar_point_limit srpl_checker u_srpl_checker (.*);
